/* rtl/mtfrs_pkg.sv */
package mtfrs_pkg;

  // Stack geometry
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned NUM_W    = 40;
  localparam int unsigned NAME_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_LIST = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW     = 3'd0,
    ST_MOVED   = 3'd1,
    ST_EVICTED = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_LISTED  = 3'd5
  } status_e;

  // Per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_ROLL
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic             hit_any;
    logic [CNT_W-1:0] fill;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

endpackage

/* rtl/mtfrs_req_if.sv */
interface mtfrs_req_if;
  logic                          valid;
  logic                          ready;
  logic [mtfrs_pkg::OP_W-1:0]    opcode;
  logic [mtfrs_pkg::NUM_W-1:0]   call_number;
  logic [mtfrs_pkg::NAME_W-1:0]  name_handle;

  modport source (output valid, output opcode, output call_number, output name_handle,
                  input ready);
  modport sink   (input valid, input opcode, input call_number, input name_handle,
                  output ready);
endinterface

/* rtl/mtfrs_rsp_if.sv */
interface mtfrs_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [mtfrs_pkg::STATUS_W-1:0]  status;
  logic [mtfrs_pkg::NUM_W-1:0]     out_number;
  logic [mtfrs_pkg::NAME_W-1:0]    out_name;
  logic [mtfrs_pkg::OCC_W-1:0]     occupancy;
  logic                            last_result;

  modport source (output valid, output status, output out_number, output out_name,
                  output occupancy, output last_result, input ready);
  modport sink   (input valid, input status, input out_number, input out_name,
                  input occupancy, input last_result, output ready);
endinterface

/* rtl/mtfrs_cell.sv */
module mtfrs_cell (
  input  logic                          clk_i,
  input  logic [mtfrs_pkg::IDX_W-1:0]   idx_i,
  input  mtfrs_pkg::cell_ctl_t          ctl_i,
  input  logic [mtfrs_pkg::NUM_W-1:0]   key_i,
  input  logic [mtfrs_pkg::NUM_W-1:0]   up_num_i,
  input  logic [mtfrs_pkg::NAME_W-1:0]  up_name_i,
  input  logic [mtfrs_pkg::NUM_W-1:0]   dn_num_i,
  input  logic [mtfrs_pkg::NAME_W-1:0]  dn_name_i,
  input  logic [mtfrs_pkg::NUM_W-1:0]   wrap_num_i,
  input  logic [mtfrs_pkg::NAME_W-1:0]  wrap_name_i,
  input  logic                          hit_chain_i,
  input  logic [mtfrs_pkg::NAME_W-1:0]  name_chain_i,
  output logic                          hit_chain_o,
  output logic [mtfrs_pkg::NAME_W-1:0]  name_chain_o,
  output logic [mtfrs_pkg::NUM_W-1:0]   num_o,
  output logic [mtfrs_pkg::NAME_W-1:0]  name_o
);

  logic [mtfrs_pkg::NUM_W-1:0]  num_q, num_d;
  logic [mtfrs_pkg::NAME_W-1:0] name_q, name_d;
  logic [mtfrs_pkg::CNT_W-1:0]  pos;
  logic                         live;
  logic                         is_last;
  logic                         hit;
  logic                         take_up;

  assign pos     = mtfrs_pkg::CNT_W'(idx_i);
  assign live    = pos < ctl_i.fill;
  assign is_last = mtfrs_pkg::CNT_W'(pos + mtfrs_pkg::CNT_W'(1)) == ctl_i.fill;
  assign hit     = live && (num_q == key_i);

  // Suffix OR: some entry at or below this cell matched
  assign hit_chain_o  = hit | hit_chain_i;
  assign name_chain_o = name_chain_i | (hit ? name_q : '0);

  // On a hit only the cells down to the hit shift; on a miss all of them do
  assign take_up = ctl_i.hit_any ? hit_chain_o : 1'b1;

  always_comb begin
    num_d  = num_q;
    name_d = name_q;
    case (ctl_i.op)
      mtfrs_pkg::CELL_PUSH: begin
        if (take_up) begin
          num_d  = up_num_i;
          name_d = up_name_i;
        end
      end
      mtfrs_pkg::CELL_ROLL: begin
        // The last live entry closes the ring by taking the old top
        if (is_last) begin
          num_d  = wrap_num_i;
          name_d = wrap_name_i;
        end else begin
          num_d  = dn_num_i;
          name_d = dn_name_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    name_q <= name_d;
  end

  assign num_o  = num_q;
  assign name_o = name_q;

endmodule

/* rtl/move_to_front_recency_stack_core.sv */
// Channel   Dir  Payload                                             Accepted when
// req_i     in   opcode, call_number, name_handle                     valid && ready
// rsp_o     out  status, out_number, out_name, occupancy, last_result valid && ready
//
// Push and pop finish at the clock edge that accepts them: on a push every cell
// compares its key at once and the row shifts in that clock edge. A list
// request on a non-empty stack streams one entry per cycle while rsp_o is free,
// rolling the live entries through the top cell. A single output register holds
// the response; a stall on rsp_o holds the stack and blocks the next request only
// once that register is full. Reset clears the fill count and control state only.
module move_to_front_recency_stack_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  mtfrs_req_if.sink   req_i,
  mtfrs_rsp_if.source rsp_o
);

  localparam int unsigned Depth = mtfrs_pkg::STACK_DEPTH;

  mtfrs_pkg::state_e              state_q, state_d;
  logic [mtfrs_pkg::CNT_W-1:0]    fill_q, fill_d;
  logic [mtfrs_pkg::CNT_W-1:0]    remain_q, remain_d;

  logic                           out_valid_q, out_valid_d;
  logic [mtfrs_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [mtfrs_pkg::NUM_W-1:0]    out_num_q, out_num_d;
  logic [mtfrs_pkg::NAME_W-1:0]   out_name_q, out_name_d;
  logic [mtfrs_pkg::OCC_W-1:0]    out_occ_q, out_occ_d;
  logic                           out_last_q, out_last_d;
  logic                           out_load;

  logic                           out_free;
  logic                           accept;
  logic                           is_empty;
  logic                           is_full;

  mtfrs_pkg::cell_op_e            cell_op;
  mtfrs_pkg::cell_ctl_t           ctl;
  logic [mtfrs_pkg::NAME_W-1:0]   load_name;

  logic [mtfrs_pkg::NUM_W-1:0]    cell_num  [Depth];
  logic [mtfrs_pkg::NAME_W-1:0]   cell_name [Depth];
  logic                           hit_c     [Depth+1];
  logic [mtfrs_pkg::NAME_W-1:0]   name_c    [Depth+1];

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == mtfrs_pkg::S_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign is_empty    = fill_q == '0;
  assign is_full     = fill_q == mtfrs_pkg::CNT_W'(Depth);

  assign ctl = '{op: cell_op, hit_any: hit_c[0], fill: fill_q};

  // A held key keeps its stored name; a new key brings the request's name
  assign load_name = hit_c[0] ? name_c[0] : req_i.name_handle;

  assign hit_c[Depth]  = 1'b0;
  assign name_c[Depth] = '0;

  // Row of cells: cell 0 is the most recent entry
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [mtfrs_pkg::NUM_W-1:0]  up_num;
    logic [mtfrs_pkg::NAME_W-1:0] up_name;
    logic [mtfrs_pkg::NUM_W-1:0]  dn_num;
    logic [mtfrs_pkg::NAME_W-1:0] dn_name;

    if (g == 0) begin : g_top
      assign up_num  = req_i.call_number;
      assign up_name = load_name;
    end else begin : g_mid
      assign up_num  = cell_num[g-1];
      assign up_name = cell_name[g-1];
    end

    if (g == Depth - 1) begin : g_bot
      assign dn_num  = cell_num[0];
      assign dn_name = cell_name[0];
    end else begin : g_up
      assign dn_num  = cell_num[g+1];
      assign dn_name = cell_name[g+1];
    end

    mtfrs_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (mtfrs_pkg::IDX_W'(g)),
      .ctl_i        (ctl),
      .key_i        (req_i.call_number),
      .up_num_i     (up_num),
      .up_name_i    (up_name),
      .dn_num_i     (dn_num),
      .dn_name_i    (dn_name),
      .wrap_num_i   (cell_num[0]),
      .wrap_name_i  (cell_name[0]),
      .hit_chain_i  (hit_c[g+1]),
      .name_chain_i (name_c[g+1]),
      .hit_chain_o  (hit_c[g]),
      .name_chain_o (name_c[g]),
      .num_o        (cell_num[g]),
      .name_o       (cell_name[g])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtfrs_pkg::S_IDLE: begin
        if (accept && req_i.opcode == mtfrs_pkg::OP_LIST && !is_empty) begin
          state_d = mtfrs_pkg::S_LIST;
        end
      end
      mtfrs_pkg::S_LIST: begin
        if (out_free && remain_q == mtfrs_pkg::CNT_W'(1)) begin
          state_d = mtfrs_pkg::S_IDLE;
        end
      end
      default: state_d = mtfrs_pkg::S_IDLE;
    endcase
  end

  // Cell command, fill count and response
  always_comb begin
    cell_op      = mtfrs_pkg::CELL_HOLD;
    fill_d       = fill_q;
    remain_d     = remain_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_num_d    = out_num_q;
    out_name_d   = out_name_q;
    out_last_d   = 1'b1;

    unique case (state_q)
      mtfrs_pkg::S_IDLE: begin
        if (accept) begin
          case (req_i.opcode)
            mtfrs_pkg::OP_PUSH: begin
              cell_op  = mtfrs_pkg::CELL_PUSH;
              out_load = 1'b1;
              if (hit_c[0]) begin
                out_status_d = mtfrs_pkg::ST_MOVED;
                out_num_d    = req_i.call_number;
                out_name_d   = name_c[0];
              end else if (is_full) begin
                // Report the bottom entry that drops off
                out_status_d = mtfrs_pkg::ST_EVICTED;
                out_num_d    = cell_num[Depth-1];
                out_name_d   = cell_name[Depth-1];
              end else begin
                out_status_d = mtfrs_pkg::ST_NEW;
                out_num_d    = req_i.call_number;
                out_name_d   = req_i.name_handle;
                fill_d       = mtfrs_pkg::CNT_W'(fill_q + mtfrs_pkg::CNT_W'(1));
              end
            end
            mtfrs_pkg::OP_POP: begin
              out_load = 1'b1;
              if (is_empty) begin
                out_status_d = mtfrs_pkg::ST_EMPTY;
                out_num_d    = '0;
                out_name_d   = '0;
              end else begin
                cell_op      = mtfrs_pkg::CELL_ROLL;
                out_status_d = mtfrs_pkg::ST_POPPED;
                out_num_d    = cell_num[0];
                out_name_d   = cell_name[0];
                fill_d       = mtfrs_pkg::CNT_W'(fill_q - mtfrs_pkg::CNT_W'(1));
              end
            end
            mtfrs_pkg::OP_LIST: begin
              if (is_empty) begin
                out_load     = 1'b1;
                out_status_d = mtfrs_pkg::ST_EMPTY;
                out_num_d    = '0;
                out_name_d   = '0;
              end else begin
                remain_d = fill_q;
              end
            end
            default: ;  // unused opcode: drop silently
          endcase
        end
      end
      mtfrs_pkg::S_LIST: begin
        // Emit the top entry and roll the live entries up by one
        if (out_free) begin
          cell_op      = mtfrs_pkg::CELL_ROLL;
          out_load     = 1'b1;
          out_status_d = mtfrs_pkg::ST_LISTED;
          out_num_d    = cell_num[0];
          out_name_d   = cell_name[0];
          out_last_d   = remain_q == mtfrs_pkg::CNT_W'(1);
          remain_d     = mtfrs_pkg::CNT_W'(remain_q - mtfrs_pkg::CNT_W'(1));
        end
      end
      default: ;
    endcase

    out_occ_d   = mtfrs_pkg::OCC_W'(fill_d);
    out_valid_d = out_load || (out_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtfrs_pkg::S_IDLE;
      fill_q      <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the response payload until a new one is loaded
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_num_q    <= out_num_d;
      out_name_q   <= out_name_d;
      out_occ_q    <= out_occ_d;
      out_last_q   <= out_last_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_number  = out_num_q;
  assign rsp_o.out_name    = out_name_q;
  assign rsp_o.occupancy   = out_occ_q;
  assign rsp_o.last_result = out_last_q;

endmodule
